// ===== rtl/core/wcpq_pkg.sv =====
// Shared types and constants of the weighted class priority queue.
package wcpq_pkg;

    localparam int CLASS_BITS     = 2;
    localparam int WEIGHT_BITS    = 3;
    localparam int STATUS_BITS    = 3;
    localparam int NUM_CLASSES    = 3;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_INSERTED = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_REMOVED  = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_NONE     = 3'd4;

    localparam logic [CLASS_BITS-1:0] CLASS_NONE  = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_ONE   = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLASS_TWO   = 2'd2;
    localparam logic [CLASS_BITS-1:0] CLASS_THREE = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_ONE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_TWO   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_THREE = 2'd2;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE_RESET   = 3'd2;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_TWO_RESET   = 3'd1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_THREE_RESET = 3'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_SELECT,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic select;
        logic shift_step;
        logic load_out;
    } ctl_t;

    typedef struct packed {
        logic accept_done;
        logic scan_last;
        logic found;
        logic shift_more;
    } dp_stat_t;

endpackage

// ===== rtl/core/wcpq_req_if.sv =====
// Request channel: command and entry to insert.
interface wcpq_req_if #(
    parameter int TAG_BITS = 16
);
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [TAG_BITS-1:0] entry_tag;
    logic [1:0]          entry_class;

    modport source (output valid, cmd, entry_tag, entry_class, input ready);
    modport sink   (input valid, cmd, entry_tag, entry_class, output ready);
endinterface

// ===== rtl/core/wcpq_rsp_if.sv =====
// Response channel: status, served entry and occupancy.
interface wcpq_rsp_if #(
    parameter int TAG_BITS = 16,
    parameter int OCC_BITS = 5
);
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [TAG_BITS-1:0] served_tag;
    logic [1:0]          served_class;
    logic [OCC_BITS-1:0] occupancy;

    modport source (output valid, status, served_tag, served_class, occupancy, input ready);
    modport sink   (input valid, status, served_tag, served_class, occupancy, output ready);
endinterface

// ===== rtl/core/wcpq_controller.sv =====
// Sequencer for insert, scan, select, compaction and response beats.
module wcpq_controller
    import wcpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output ctl_t     ctl
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = stat.accept_done ? S_RESP : S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_SELECT;
            end
            S_SELECT:
            begin
                ctl.select = 1'b1;
                state_next = stat.found ? S_SHIFT : S_RESP;
            end
            S_SHIFT:
            begin
                ctl.shift_step = 1'b1;
                if (!stat.shift_more)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== rtl/core/wcpq_datapath.sv =====
// Entry memory, credits, scan record, compaction pointers and result registers.
module wcpq_datapath
    import wcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WEIGHT_BITS-1:0]    cfg_data,
    input  logic                      cmd,
    input  logic [TAG_BITS-1:0]       entry_tag,
    input  logic [CLASS_BITS-1:0]     entry_class,
    input  ctl_t                      ctl,
    output dp_stat_t                  stat,
    output logic [STATUS_BITS-1:0]    status,
    output logic [TAG_BITS-1:0]       served_tag,
    output logic [CLASS_BITS-1:0]     served_class,
    output logic [CW-1:0]             occupancy
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WW = TAG_BITS + CLASS_BITS;

    logic [WEIGHT_BITS-1:0] weight_reg [NUM_CLASSES];
    logic [WEIGHT_BITS-1:0] credit_reg [NUM_CLASSES];
    logic [WEIGHT_BITS-1:0] credit_eff [NUM_CLASSES];
    logic [WEIGHT_BITS-1:0] credit_pick [NUM_CLASSES];
    logic                   credit_zero;
    logic [CLASS_BITS-1:0]  pick_want;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CLASS_BITS-1:0]  want_reg;
    logic [CW-1:0]          rd_ptr_reg;
    logic [CW-1:0]          rd_ptr_next;
    logic [AW-1:0]          wr_ptr_reg;
    logic [AW-1:0]          wr_ptr_next;

    logic [WW-1:0]          mem [QUEUE_DEPTH];
    logic [WW-1:0]          rdata_reg;
    logic                   rd_vld_reg;
    logic                   rd_scan_reg;
    logic [AW-1:0]          rd_idx_reg;
    logic                   rd_issue;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WW-1:0]          mem_wdata;
    logic [CLASS_BITS-1:0]  rd_class;

    logic                   hit_reg [NUM_CLASSES];
    logic [AW-1:0]          hit_idx_reg [NUM_CLASSES];
    logic [TAG_BITS-1:0]    hit_tag_reg [NUM_CLASSES];

    logic                   is_insert;
    logic                   insert_ok;
    logic                   shift_more;
    logic                   sel_found;
    logic [CLASS_BITS-1:0]  sel_class;
    logic [1:0]             sel_slot;

    logic [STATUS_BITS-1:0] res_status_reg;
    logic [TAG_BITS-1:0]    res_tag_reg;
    logic [CLASS_BITS-1:0]  res_class_reg;
    logic [CW-1:0]          res_occ_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [TAG_BITS-1:0]    served_tag_reg;
    logic [CLASS_BITS-1:0]  served_class_reg;
    logic [CW-1:0]          occupancy_reg;

    // weight and credit pick
    always_comb
    begin
        credit_zero = (credit_reg[0] == '0) && (credit_reg[1] == '0) && (credit_reg[2] == '0);
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            credit_eff[k]  = credit_zero ? weight_reg[k] : credit_reg[k];
            credit_pick[k] = credit_eff[k];
        end
        pick_want = CLASS_NONE;
        if (credit_eff[2] != '0)
        begin
            pick_want      = CLASS_THREE;
            credit_pick[2] = credit_eff[2] - WEIGHT_BITS'(1);
        end
        else if (credit_eff[0] != '0)
        begin
            pick_want      = CLASS_ONE;
            credit_pick[0] = credit_eff[0] - WEIGHT_BITS'(1);
        end
        else if (credit_eff[1] != '0)
        begin
            pick_want      = CLASS_TWO;
            credit_pick[1] = credit_eff[1] - WEIGHT_BITS'(1);
        end
    end

    assign is_insert  = (cmd == CMD_INSERT);
    assign insert_ok  = (count_reg < CW'(QUEUE_DEPTH)) && (entry_class != CLASS_NONE);
    assign shift_more = (rd_ptr_reg <= count_reg);
    assign rd_issue   = ctl.scan_step || (ctl.shift_step && shift_more);
    assign rd_class   = rdata_reg[WW-1:TAG_BITS];

    // oldest entry of the wanted class, with fallback
    always_comb
    begin
        sel_found = 1'b0;
        sel_class = CLASS_NONE;
        case (want_reg)
            CLASS_THREE:
            begin
                if (hit_reg[2])
                begin
                    sel_found = 1'b1;
                    sel_class = CLASS_THREE;
                end
                else if (hit_reg[0])
                begin
                    sel_found = 1'b1;
                    sel_class = CLASS_ONE;
                end
                else if (hit_reg[1])
                begin
                    sel_found = 1'b1;
                    sel_class = CLASS_TWO;
                end
            end
            CLASS_ONE:
            begin
                if (hit_reg[0])
                begin
                    sel_found = 1'b1;
                    sel_class = CLASS_ONE;
                end
                else if (hit_reg[1])
                begin
                    sel_found = 1'b1;
                    sel_class = CLASS_TWO;
                end
            end
            CLASS_TWO:
            begin
                if (hit_reg[1])
                begin
                    sel_found = 1'b1;
                    sel_class = CLASS_TWO;
                end
            end
            default:
            begin
                sel_found = 1'b0;
            end
        endcase
        sel_slot = sel_class - 2'd1;
    end

    assign stat.accept_done = is_insert || (count_reg == '0) || (pick_want == CLASS_NONE);
    assign stat.scan_last   = (rd_ptr_reg == count_reg - CW'(1));
    assign stat.found       = sel_found;
    assign stat.shift_more  = shift_more;

    // memory write mux: insert at tail, or compaction move
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_ptr_reg;
        mem_wdata = rdata_reg;
        if (ctl.accept && is_insert && insert_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[AW-1:0];
            mem_wdata = {entry_class, entry_tag};
        end
        else if (rd_vld_reg && !rd_scan_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_issue)
        begin
            rdata_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    // pointers and count
    always_comb
    begin
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (ctl.accept)
        begin
            rd_ptr_next = '0;
            if (is_insert && insert_ok)
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (ctl.select)
        begin
            if (sel_found)
            begin
                count_next  = count_reg - CW'(1);
                wr_ptr_next = hit_idx_reg[sel_slot];
                rd_ptr_next = CW'(hit_idx_reg[sel_slot]) + CW'(1);
            end
        end
        else
        begin
            if (rd_issue)
            begin
                rd_ptr_next = rd_ptr_reg + CW'(1);
            end
            if (rd_vld_reg && !rd_scan_reg)
            begin
                wr_ptr_next = wr_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg[0] <= WEIGHT_ONE_RESET;
            weight_reg[1] <= WEIGHT_TWO_RESET;
            weight_reg[2] <= WEIGHT_THREE_RESET;
            credit_reg[0] <= WEIGHT_ONE_RESET;
            credit_reg[1] <= WEIGHT_TWO_RESET;
            credit_reg[2] <= WEIGHT_THREE_RESET;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                hit_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WEIGHT_ONE:   weight_reg[0] <= cfg_data;
                    REG_WEIGHT_TWO:   weight_reg[1] <= cfg_data;
                    REG_WEIGHT_THREE: weight_reg[2] <= cfg_data;
                    default:          weight_reg[0] <= weight_reg[0];
                endcase
            end
            if (ctl.accept && !is_insert && (count_reg != '0))
            begin
                for (int k = 0; k < NUM_CLASSES; k++)
                begin
                    credit_reg[k] <= credit_pick[k];
                end
            end
            count_reg  <= count_next;
            rd_vld_reg <= rd_issue;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                if (ctl.accept)
                begin
                    hit_reg[k] <= 1'b0;
                end
                else if (rd_vld_reg && rd_scan_reg && (rd_class == CLASS_BITS'(k + 1)))
                begin
                    hit_reg[k] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        if (rd_issue)
        begin
            rd_scan_reg <= ctl.scan_step;
            rd_idx_reg  <= rd_ptr_reg[AW-1:0];
        end
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if (rd_vld_reg && rd_scan_reg && !hit_reg[k]
                && (rd_class == CLASS_BITS'(k + 1)))
            begin
                hit_idx_reg[k] <= rd_idx_reg;
                hit_tag_reg[k] <= rdata_reg[TAG_BITS-1:0];
            end
        end
        if (ctl.accept)
        begin
            want_reg    <= pick_want;
            res_tag_reg   <= '0;
            res_class_reg <= CLASS_NONE;
            res_occ_reg   <= count_next;
            if (is_insert)
            begin
                res_status_reg <= insert_ok ? STATUS_INSERTED : STATUS_FULL;
            end
            else if (count_reg == '0)
            begin
                res_status_reg <= STATUS_EMPTY;
            end
            else
            begin
                res_status_reg <= STATUS_NONE;
            end
        end
        else if (ctl.select)
        begin
            res_occ_reg <= count_next;
            if (sel_found)
            begin
                res_status_reg <= STATUS_REMOVED;
                res_tag_reg    <= hit_tag_reg[sel_slot];
                res_class_reg  <= sel_class;
            end
        end
        if (ctl.load_out)
        begin
            status_reg       <= res_status_reg;
            served_tag_reg   <= res_tag_reg;
            served_class_reg <= res_class_reg;
            occupancy_reg    <= res_occ_reg;
        end
    end

    assign status       = status_reg;
    assign served_tag   = served_tag_reg;
    assign served_class = served_class_reg;
    assign occupancy    = occupancy_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan_step |-> !mem_we)
        else $error("memory written during class scan");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.select && sel_found) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("count not reduced after removal");

    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg && !rd_scan_reg) |-> (rd_idx_reg == wr_ptr_reg + AW'(1)))
        else $error("compaction move not one slot down");

endmodule

// ===== rtl/core/weighted_class_priority_queue.sv =====
// Top level of the weighted class priority queue.
//
// req carries one beat per command: insert (cmd 0) appends entry_tag and
// entry_class at the tail; remove (cmd 1) serves the oldest entry of the
// class chosen by the weighted credits (class 3, then 1, then 2, with
// fallback 3 -> 1 -> 2). rsp returns exactly one beat per request beat with
// status, served tag and class, and the occupancy after the command.
// Weights are to be written by the user on cfg_we/cfg_index/cfg_data only
// while no command is open; the block itself does not enforce this. One
// command is in flight at a time. An insert or a refused command goes from
// the request beat to the result registers, then in S_RESP to the response
// register. A remove reads each held slot once to scan the classes, then
// moves each slot above the served one down by one to compact the memory.
// After reset the queue is empty, the weights and credits are 2, 1, 3, and
// no clearing pass is needed. A stalled rsp holds its beat in the output
// register while the next request is already accepted and worked on.
module weighted_class_priority_queue
    import wcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    wcpq_req_if.sink                  req,
    wcpq_rsp_if.source                rsp,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WEIGHT_BITS-1:0]    cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    ctl_t     ctl;
    dp_stat_t stat;

    wcpq_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    wcpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .CW          (CW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (req.cmd),
        .entry_tag    (req.entry_tag),
        .entry_class  (req.entry_class),
        .ctl          (ctl),
        .stat         (stat),
        .status       (rsp.status),
        .served_tag   (rsp.served_tag),
        .served_class (rsp.served_class),
        .occupancy    (rsp.occupancy)
    );

endmodule
